// ----- hw/rtl/orl_pkg.sv -----
// orl_pkg: sizes, codes and shared types of the ordered rank list
// no dependencies; used by every module under hw/rtl
package orl_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_BITS   = 32;
    localparam int KEY_IN_W   = 32;
    localparam int POS_W      = 8;
    localparam int RANK_W     = 8;

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int POS_CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RANK_EXT_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    // rank count: flags are counted in groups, group counts summed a window a cycle
    localparam int GROUP      = 16;
    localparam int GRP_CNT_W  = $clog2(GROUP + 1);
    localparam int N_GROUPS   = (CAPACITY + GROUP - 1) / GROUP;
    localparam int N_STEPS    = (N_GROUPS + GROUP - 1) / GROUP;
    localparam int PART_N     = N_STEPS * GROUP;
    localparam int STEP_W     = $clog2(N_STEPS + 1);

    localparam logic REQ_INSERT      = 1'b0;
    localparam logic REQ_REMOVE      = 1'b1;
    localparam logic STATUS_INSERTED = 1'b0;
    localparam logic STATUS_FULL     = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [KEY_BITS-1:0]  key;
        logic [IDX_W-1:0]     at;
        logic [CNT_W-1:0]     count;
        logic                 descending;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_COMPARE,
        ST_SUM,
        ST_WRITE
    } t_state;

    function automatic logic [KEY_BITS-1:0] fit_key(input logic [KEY_IN_W-1:0] key_in);
        logic [63:0] wide;
        wide = {32'b0, key_in};
        return wide[KEY_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/orl_cell.sv -----
// orl_cell: one slot of the list, holds a key, compares it with the new key
// and shifts toward or away from its neighbors; uses orl_pkg
module orl_cell (
    input  logic                          i_clk,
    input  logic [orl_pkg::IDX_W-1:0]     i_index,
    input  orl_pkg::t_cell_cmd            i_cmd,
    input  logic [orl_pkg::KEY_BITS-1:0]  i_left_key,
    input  logic [orl_pkg::KEY_BITS-1:0]  i_right_key,
    output logic [orl_pkg::KEY_BITS-1:0]  o_key,
    output logic                          o_prec
);
    import orl_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                w_used;

    assign w_used = CNT_W'(i_index) < i_cmd.count;

    // stored key ties or comes before the new key in list order
    assign o_prec = w_used && (i_cmd.descending ? (r_key >= i_cmd.key)
                                                : (r_key <= i_cmd.key));
    assign o_key  = r_key;

    always_comb begin
        n_key = r_key;
        unique case (i_cmd.op)
            CELL_INSERT: begin
                if (i_index == i_cmd.at) begin
                    n_key = i_cmd.key;
                end else if (i_index > i_cmd.at) begin
                    n_key = i_left_key;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_cmd.at) begin
                    n_key = i_right_key;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

// ----- hw/rtl/orl_rank_count.sv -----
// orl_rank_count: counts the set compare flags of the cell row, group
// counts first, then a window of group counts per cycle; uses orl_pkg
module orl_rank_count (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [orl_pkg::CAPACITY-1:0]  i_flags,
    input  logic                          i_load,
    input  logic                          i_step,
    output logic [orl_pkg::CNT_W-1:0]     o_rank,
    output logic                          o_last
);
    import orl_pkg::*;

    logic [GRP_CNT_W-1:0]      r_part [PART_N];
    logic [CNT_W-1:0]          r_acc;
    logic [STEP_W-1:0]         r_step;
    logic [PART_N*GROUP-1:0]   w_flags_pad;
    logic [GRP_CNT_W-1:0]      w_group_cnt [PART_N];
    logic [CNT_W-1:0]          w_window_sum;

    function automatic logic [GRP_CNT_W-1:0] popcount_group(input logic [GROUP-1:0] bits);
        logic [2:0]           nib [GROUP/4];
        logic [GRP_CNT_W-1:0] total;
        for (int q = 0; q < GROUP / 4; q++) begin
            nib[q] = 3'(bits[4*q]) + 3'(bits[4*q+1]) + 3'(bits[4*q+2]) + 3'(bits[4*q+3]);
        end
        total = '0;
        for (int q = 0; q < GROUP / 4; q++) begin
            total = total + GRP_CNT_W'(nib[q]);
        end
        return total;
    endfunction

    always_comb begin
        w_flags_pad = '0;
        w_flags_pad[CAPACITY-1:0] = i_flags;
    end

    for (genvar g = 0; g < PART_N; g++) begin : g_group
        assign w_group_cnt[g] = popcount_group(w_flags_pad[g*GROUP +: GROUP]);
    end

    // window of GROUP partial counts, added as quads then onto the running sum
    always_comb begin
        logic [CNT_W-1:0] quad [GROUP/4];
        for (int q = 0; q < GROUP / 4; q++) begin
            quad[q] = CNT_W'(r_part[4*q]) + CNT_W'(r_part[4*q+1])
                    + CNT_W'(r_part[4*q+2]) + CNT_W'(r_part[4*q+3]);
        end
        w_window_sum = r_acc;
        for (int q = 0; q < GROUP / 4; q++) begin
            w_window_sum = w_window_sum + quad[q];
        end
    end

    for (genvar g = 0; g < PART_N; g++) begin : g_part
        if (g + GROUP < PART_N) begin : g_shift
            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_part[g] <= w_group_cnt[g];
                end else if (i_step) begin
                    r_part[g] <= r_part[g+GROUP];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_load) begin
                    r_part[g] <= w_group_cnt[g];
                end else if (i_step) begin
                    r_part[g] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_load) begin
            r_acc <= '0;
        end else if (i_step) begin
            r_acc <= w_window_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_load) begin
            r_step <= '0;
        end else if (i_step) begin
            r_step <= r_step + 1'b1;
        end
    end

    assign o_rank = r_acc;
    assign o_last = r_step == STEP_W'(N_STEPS - 1);

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_W'(N_STEPS))
        else $error("rank step counter ran past the last window");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_acc == '0 && r_step == '0)
        else $error("rank sum not restarted on load");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= CNT_W'(CAPACITY))
        else $error("rank sum exceeds capacity");

endmodule

// ----- hw/rtl/ordered_rank_list.sv -----
// ordered rank list: a row of CAPACITY cells keeps keys in list order
// insert: compare and group count, one window sum per GROUP groups, shift, output register;
// a new word is taken only back in idle, after the result is loaded into the output register
// remove and full insert skip the compare and sum; reset clears the entry count and sets descending
// order, stored keys are left as they are and need no clearing pass
module ordered_rank_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [orl_pkg::KEY_IN_W-1:0]  i_key,
    input  logic [orl_pkg::POS_W-1:0]     i_position,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [orl_pkg::RANK_W-1:0]    o_rank,
    output logic                          o_status
);
    import orl_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic                  r_descending;
    logic [CNT_W-1:0]      r_count;
    logic [KEY_BITS-1:0]   r_key;
    logic [POS_W-1:0]      r_pos;
    logic                  r_out_valid;
    logic [RANK_W-1:0]     r_rank;
    logic                  r_status;

    t_cell_cmd             w_cmd;
    logic [KEY_BITS-1:0]   w_cell_key  [CAPACITY];
    logic [KEY_BITS-1:0]   w_left_key  [CAPACITY];
    logic [KEY_BITS-1:0]   w_right_key [CAPACITY];
    logic [CAPACITY-1:0]   w_prec;
    logic [CNT_W-1:0]      w_rank;
    logic                  w_last;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_out_free;
    logic                  w_pos_ok;
    logic [POS_CMP_W-1:0]  w_pos_ext;
    logic [RANK_EXT_W-1:0] w_rank_ext;
    logic                  w_load;
    logic                  w_step;
    logic                  w_out_load;
    logic                  w_do_insert;
    logic                  w_do_remove;

    assign w_accept   = i_valid && o_ready;
    assign w_full     = r_count == CNT_W'(CAPACITY);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_pos_ext  = POS_CMP_W'(r_pos);
    assign w_pos_ok   = w_pos_ext < POS_CMP_W'(r_count);
    assign w_rank_ext = RANK_EXT_W'(w_rank);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_REMOVE) begin
                        n_state = ST_REMOVE;
                    end else if (w_full) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_COMPARE;
                    end
                end
            end
            ST_REMOVE:  n_state = ST_IDLE;
            ST_COMPARE: n_state = ST_SUM;
            ST_SUM: begin
                if (w_last) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready     = 1'b0;
        w_load      = 1'b0;
        w_step      = 1'b0;
        w_out_load  = 1'b0;
        w_do_insert = 1'b0;
        w_do_remove = 1'b0;
        unique case (r_state)
            ST_IDLE:    o_ready = 1'b1;
            ST_REMOVE:  w_do_remove = w_pos_ok;
            ST_COMPARE: w_load = 1'b1;
            ST_SUM:     w_step = 1'b1;
            ST_WRITE: begin
                w_out_load  = w_out_free;
                w_do_insert = w_out_free && !w_full;
            end
            default: o_ready = 1'b0;
        endcase
    end

    always_comb begin
        w_cmd.op         = CELL_HOLD;
        w_cmd.at         = w_rank[IDX_W-1:0];
        if (w_do_insert) begin
            w_cmd.op = CELL_INSERT;
        end else if (w_do_remove) begin
            w_cmd.op = CELL_REMOVE;
            w_cmd.at = w_pos_ext[IDX_W-1:0];
        end
        w_cmd.key        = r_key;
        w_cmd.count      = r_count;
        w_cmd.descending = r_descending;
    end

    // cell row: each cell shifts from its left neighbor on insert, right on remove
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left_key[i] = r_key;
        end else begin : g_inner_l
            assign w_left_key[i] = w_cell_key[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right_key[i] = w_cell_key[i];
        end else begin : g_inner_r
            assign w_right_key[i] = w_cell_key[i+1];
        end

        orl_cell u_cell (
            .i_clk       (i_clk),
            .i_index     (IDX_W'(i)),
            .i_cmd       (w_cmd),
            .i_left_key  (w_left_key[i]),
            .i_right_key (w_right_key[i]),
            .o_key       (w_cell_key[i]),
            .o_prec      (w_prec[i])
        );
    end

    orl_rank_count u_rank_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_prec),
        .i_load  (w_load),
        .i_step  (w_step),
        .o_rank  (w_rank),
        .o_last  (w_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_descending <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_descending <= i_cfg_data;
            end
            if (w_do_insert) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_remove) begin
                r_count <= r_count - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= fit_key(i_key);
            r_pos <= i_position;
        end
        if (w_out_load) begin
            r_rank   <= w_full ? '0 : w_rank_ext[RANK_W-1:0];
            r_status <= w_full ? STATUS_FULL : STATUS_INSERTED;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_rank   = r_rank;
    assign o_status = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state) == ST_REMOVE || $past(r_state) == ST_WRITE)
        else $error("entry count changed outside remove or write");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load && w_full |=> o_valid && o_status == STATUS_FULL && o_rank == '0)
        else $error("full insert not flagged");

    a_remove_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_REMOVE |=> r_state == ST_REMOVE)
        else $error("remove word took the wrong path");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_state != ST_WRITE |=> !o_valid)
        else $error("taken result word still shown");

endmodule

// ----- verif/orl_checker.sv -----
`timescale 1ns / 100ps
// orl_checker: watches the request and result channels of ordered_rank_list,
// keeps its own sorted copy of the list and compares every rank word it returns
// depends on orl_pkg for sizes and codes
module orl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_req_type,
    input  logic [orl_pkg::KEY_IN_W-1:0]  i_key,
    input  logic [orl_pkg::POS_W-1:0]     i_position,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [orl_pkg::RANK_W-1:0]    i_rank,
    input  logic                          i_status,
    output int                            o_pending,
    output int                            o_errors
);
    import orl_pkg::*;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              status;
    } t_rank_word;

    logic [KEY_BITS-1:0] sorted_keys [CAPACITY];
    int unsigned         sorted_len;
    logic                largest_first;
    t_rank_word          rank_q [$];
    int                  error_count = 0;

    task automatic place_key(input logic [KEY_BITS-1:0] k, output t_rank_word res);
        int unsigned r;
        int unsigned i;
        r = 0;
        if (sorted_len >= CAPACITY) begin
            res.rank   = '0;
            res.status = STATUS_FULL;
        end else begin
            // new key lands after every entry that ties with it
            for (i = 0; i < sorted_len; i++) begin
                if (largest_first ? (sorted_keys[i] >= k) : (sorted_keys[i] <= k))
                    r++;
            end
            for (i = sorted_len; i > r; i--)
                sorted_keys[i] = sorted_keys[i - 1];
            sorted_keys[r] = k;
            sorted_len++;
            res.rank   = RANK_W'(r);
            res.status = STATUS_INSERTED;
        end
    endtask

    task automatic drop_entry(input logic [POS_W-1:0] pos);
        int unsigned i;
        if (pos < sorted_len) begin
            for (i = pos; i + 1 < sorted_len; i++)
                sorted_keys[i] = sorted_keys[i + 1];
            sorted_len--;
        end
    endtask

    always @(posedge i_clk) begin
        t_rank_word want;
        t_rank_word res;
        if (!i_rst_n) begin
            sorted_len    = 0;
            largest_first = 1'b1;
            rank_q.delete();
        end else begin
            if (i_cfg_we)
                largest_first = i_cfg_data;
            // retire before queueing so a same-edge request cannot be matched early
            if (i_res_valid && i_res_ready) begin
                if (rank_q.size() == 0) begin
                    $error("unexpected result word: rank %0d status %0b", i_rank, i_status);
                    error_count++;
                end else begin
                    want = rank_q.pop_front();
                    if (i_rank !== want.rank) begin
                        $error("rank: expected %0d, actual %0d", want.rank, i_rank);
                        error_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0b, actual %0b", want.status, i_status);
                        error_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_type == REQ_REMOVE) begin
                    drop_entry(i_position);
                end else begin
                    place_key(i_key[KEY_BITS-1:0], res);
                    rank_q.push_back(res);
                end
            end
        end
        o_pending <= rank_q.size();
        o_errors  <= error_count;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives insert and remove words into ordered_rank_list under random
// bursts and result stalls, switches the list order between phases
// depends on orl_pkg, ordered_rank_list and orl_checker
module tb_top;
    import orl_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_COMB
    } t_sink_mode;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic                 i_cfg_data = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    logic                 i_req_type = REQ_INSERT;
    logic [KEY_IN_W-1:0]  i_key      = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    logic [RANK_W-1:0]    o_rank;
    logic                 o_status;

    int                   pending;
    int                   errors;
    int                   cycle_count  = 0;
    int unsigned          entries_held = 0;
    t_sink_mode           sink_mode    = SINK_OPEN;
    int                   sink_left    = 0;

    ordered_rank_list u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rank     (o_rank),
        .o_status   (o_status)
    );

    orl_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_valid),
        .i_req_ready (o_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_position  (i_position),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_rank      (o_rank),
        .i_status    (o_status),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: stall style is picked anew each time its random countdown runs out
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_left <= $urandom_range(20, 120);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:  i_ready <= 1'b1;
            SINK_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: i_ready <= ($urandom_range(0, 3) == 0);
            default:    i_ready <= (cycle_count[2:0] != 3'd0);
        endcase
    end

    task automatic send_word(input logic req, input logic [KEY_IN_W-1:0] key,
                             input logic [POS_W-1:0] pos);
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        if (req == REQ_INSERT) begin
            if (entries_held < CAPACITY)
                entries_held++;
        end else if (pos < entries_held) begin
            entries_held--;
        end
    endtask

    // wait for the list to go quiet, then change the order
    task automatic set_order(input logic descending);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= descending;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(input int words, input int insert_pct);
        int                  sent;
        int                  burst;
        logic                req;
        logic [KEY_IN_W-1:0] key;
        logic [POS_W-1:0]    pos;
        sent = 0;
        while (sent < words) begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < words) begin
                req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
                // mix of wide keys, narrow ranges for ties, and boundary values
                case ($urandom_range(0, 3))
                    0: key = $urandom();
                    1: key = $urandom_range(0, 7);
                    2: key = {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                              {(KEY_IN_W-1){$urandom_range(0, 1) ? 1'b1 : 1'b0}}};
                    default: key = $urandom_range(0, 65535);
                endcase
                if (entries_held > 0 && $urandom_range(0, 7) != 0)
                    pos = POS_W'($urandom_range(0, entries_held - 1));
                else
                    pos = POS_W'($urandom_range(0, 255));
                send_word(req, key, pos);
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_order(1'b1);
        send_word(REQ_REMOVE, '0, 8'd0);            // empty list, ignored
        send_word(REQ_INSERT, 32'h0000_0000, '0);
        send_word(REQ_INSERT, 32'hFFFF_FFFF, '0);
        send_word(REQ_INSERT, 32'h8000_0000, '0);
        send_word(REQ_INSERT, 32'h8000_0000, '0);   // tie goes after the equal key
        send_word(REQ_INSERT, 32'h7FFF_FFFF, '0);
        send_word(REQ_INSERT, 32'h0000_0001, '0);
        send_word(REQ_REMOVE, '0, 8'd255);          // past the end
        send_word(REQ_REMOVE, '0, 8'd6);            // exactly at the count
        send_word(REQ_REMOVE, '0, 8'd0);
        send_word(REQ_REMOVE, '0, 8'd4);            // last entry
        send_word(REQ_INSERT, 32'h8000_0000, '0);

        // flip order with entries still stored
        set_order(1'b0);
        send_word(REQ_INSERT, 32'h8000_0000, '0);
        send_word(REQ_INSERT, 32'h0000_0000, '0);
        send_word(REQ_INSERT, 32'hFFFF_FFFF, '0);
        send_word(REQ_INSERT, 32'h5555_5555, 8'hAA);
        send_word(REQ_INSERT, 32'hAAAA_AAAA, 8'h55);
        send_word(REQ_REMOVE, 32'hFFFF_FFFF, 8'd2);

        set_order(1'b1);
        run_random(150, 55);
        // mostly inserts: fills the list and runs into the full case
        set_order(1'b0);
        run_random(300, 96);
        set_order(1'b1);
        run_random(200, 35);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
